// ===== sv/ray_aabb_closest_hit_picker_unit_assert.svh =====
// Assertion macros used by the checker file.
`ifndef RAY_AABB_CLOSEST_HIT_PICKER_UNIT_ASSERT_SVH
`define RAY_AABB_CLOSEST_HIT_PICKER_UNIT_ASSERT_SVH
`define RAHP_ASSERT_IMPL(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define RAHP_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

// ===== sv/rahp_pkg.sv =====
// ----------------------------------------------------------------------------
// rahp_pkg
// Types, constants and arithmetic helpers of the ray box hit picker.
// ----------------------------------------------------------------------------
package rahp_pkg;
   localparam int FRAC_BITS = 16;
   localparam int NUM_REGS = 6;
   localparam logic [30:0] DIST_RESET = 31'h7FFF_FFFF;
   localparam logic [2:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [2:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [2:0] CSR_INV_X = 3'd3;
   localparam logic [2:0] CSR_INV_Y = 3'd4;
   localparam logic [2:0] CSR_INV_Z = 3'd5;

   typedef struct packed {
      logic [15:0] entity_id;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic [30:0] half_x;
      logic [30:0] half_y;
      logic [30:0] half_z;
      logic signed [31:0] scale_x;
      logic signed [31:0] scale_y;
      logic signed [31:0] scale_z;
      logic last_entity;
   } req_type;

   typedef struct packed {
      logic found;
      logic [15:0] hit_id;
      logic [30:0] hit_distance;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCALE, ST_BOUND, ST_SLAB, ST_DECIDE, ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic [1:0] axis;
      logic do_scale;
      logic do_bound;
      logic do_slab;
      logic do_decide;
      logic emit_clear;
   } cmd_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -66'sd2147483648) begin
         return 32'sh8000_0000;
      end else begin
         return v[31:0];
      end
   endfunction

   function automatic logic signed [31:0] fx_mul(input logic signed [32:0] a,
                                                 input logic signed [32:0] b);
      logic signed [65:0] p;
      p = (a * b) >>> FRAC_BITS;
      return sat32(p);
   endfunction
endpackage

// ===== sv/rahp_if.sv =====
// ----------------------------------------------------------------------------
// rahp_if
// Valid/ready channel interfaces of the ray box hit picker.
// ----------------------------------------------------------------------------
interface rahp_req_if;
   import rahp_pkg::*;
   logic valid;
   logic ready;
   req_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

interface rahp_rsp_if;
   import rahp_pkg::*;
   logic valid;
   logic ready;
   rsp_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface

interface rahp_csr_if;
   logic valid;
   logic ready;
   logic [2:0] index;
   logic [31:0] wdata;
   modport source(output valid, output index, output wdata, input ready);
   modport sink(input valid, input index, input wdata, output ready);
endinterface

// ===== sv/rahp_ctrl.sv =====
// ----------------------------------------------------------------------------
// rahp_ctrl
// Sequencer: per axis one scale step, one bound step and one slab step.
// ----------------------------------------------------------------------------
module rahp_ctrl (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_last,
   input logic rsp_busy,
   output logic req_ready,
   output rahp_pkg::cmd_type cmd
);
   import rahp_pkg::*;
   state_type state_ff, state_in;
   logic [1:0] axis_ff, axis_in;
   logic last_ff, last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         axis_ff <= 2'd0;
         last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff <= axis_in;
         last_ff <= last_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      axis_in = axis_ff;
      last_in = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCALE;
               axis_in = 2'd0;
               last_in = req_last;
            end
         end
         ST_SCALE: state_in = ST_BOUND;
         ST_BOUND: state_in = ST_SLAB;
         ST_SLAB: begin
            if (axis_ff == 2'd2) begin
               state_in = ST_DECIDE;
            end else begin
               state_in = ST_SCALE;
               axis_in = axis_ff + 2'd1;
            end
         end
         ST_DECIDE: state_in = last_ff ? ST_OUT : ST_IDLE;
         ST_OUT: begin
            if (!rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      cmd = '0;
      cmd.axis = axis_ff;
      cmd.load = (state_ff == ST_IDLE) && req_valid;
      cmd.do_scale = (state_ff == ST_SCALE);
      cmd.do_bound = (state_ff == ST_BOUND);
      cmd.do_slab = (state_ff == ST_SLAB);
      cmd.do_decide = (state_ff == ST_DECIDE);
      cmd.emit_clear = (state_ff == ST_OUT) && !rsp_busy;
   end
endmodule

// ===== sv/rahp_datapath.sv =====
// ----------------------------------------------------------------------------
// rahp_datapath
// Configuration registers, multipliers, slab bounds and best hit.
// ----------------------------------------------------------------------------
module rahp_datapath (
   input logic clock,
   input logic reset,
   input logic csr_we,
   input logic [2:0] csr_index,
   input logic [31:0] csr_wdata,
   input rahp_pkg::req_type req_data,
   input rahp_pkg::cmd_type cmd,
   input logic rsp_ready,
   output logic rsp_valid,
   output rahp_pkg::rsp_type rsp_data,
   output logic rsp_busy
);
   import rahp_pkg::*;
   logic signed [31:0] origin_ff [3];
   logic signed [31:0] inv_ff [3];
   req_type item_ff;
   logic signed [31:0] hs_ff, lo_ff, hi_ff, enter_ff, exit_ff;
   logic [30:0] best_dist_ff;
   logic [15:0] best_id_ff;
   logic any_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;
   logic signed [31:0] c, s, o, inv, t1, t2, tmin, tmax, t;
   logic [30:0] h;
   logic hit;

   always_comb begin
      unique case (cmd.axis)
         2'd0: begin c = item_ff.center_x; h = item_ff.half_x; s = item_ff.scale_x; end
         2'd1: begin c = item_ff.center_y; h = item_ff.half_y; s = item_ff.scale_y; end
         default: begin c = item_ff.center_z; h = item_ff.half_z; s = item_ff.scale_z; end
      endcase
      o = origin_ff[cmd.axis];
      inv = inv_ff[cmd.axis];
      t1 = fx_mul(33'(sat32(66'(lo_ff) - 66'(o))), 33'(inv));
      t2 = fx_mul(33'(sat32(66'(hi_ff) - 66'(o))), 33'(inv));
      tmin = (t1 < t2) ? t1 : t2;
      tmax = (t1 < t2) ? t2 : t1;
      hit = !((enter_ff > exit_ff) || (exit_ff < 0));
      t = (enter_ff >= 0) ? enter_ff : exit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff[0] <= '0;
         origin_ff[1] <= '0;
         origin_ff[2] <= '0;
         inv_ff[0] <= 32'sd65536;
         inv_ff[1] <= 32'sd65536;
         inv_ff[2] <= 32'sd65536;
         best_dist_ff <= DIST_RESET;
         best_id_ff <= '0;
         any_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_ORIGIN_X: origin_ff[0] <= csr_wdata;
               CSR_ORIGIN_Y: origin_ff[1] <= csr_wdata;
               CSR_ORIGIN_Z: origin_ff[2] <= csr_wdata;
               CSR_INV_X: inv_ff[0] <= csr_wdata;
               CSR_INV_Y: inv_ff[1] <= csr_wdata;
               CSR_INV_Z: inv_ff[2] <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.do_decide && hit && (t[30:0] < best_dist_ff)) begin
            best_dist_ff <= t[30:0];
            best_id_ff <= item_ff.entity_id;
            any_ff <= 1'b1;
         end
         if (cmd.emit_clear) begin
            rsp_valid_ff <= 1'b1;
            best_dist_ff <= DIST_RESET;
            best_id_ff <= '0;
            any_ff <= 1'b0;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
         enter_ff <= 32'sh8000_0000;
         exit_ff <= 32'sh7FFF_FFFF;
      end
      if (cmd.do_scale) begin
         hs_ff <= fx_mul(33'({1'b0, h}), 33'(s));
      end
      if (cmd.do_bound) begin
         lo_ff <= sat32(66'(c) - 66'(hs_ff));
         hi_ff <= sat32(66'(c) + 66'(hs_ff));
      end
      if (cmd.do_slab) begin
         if (tmin > enter_ff) enter_ff <= tmin;
         if (tmax < exit_ff) exit_ff <= tmax;
      end
      if (cmd.emit_clear) begin
         rsp_ff.found <= any_ff;
         rsp_ff.hit_id <= any_ff ? best_id_ff : 16'd0;
         rsp_ff.hit_distance <= any_ff ? best_dist_ff : 31'd0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign rsp_busy = rsp_valid_ff && !rsp_ready;
endmodule

// ===== sv/ray_aabb_closest_hit_picker_unit.sv =====
// ----------------------------------------------------------------------------
// ray_aabb_closest_hit_picker_unit
// Slab test of entity boxes against a configured ray, nearest hit kept.
//
//   channel  dir  role
//   req      in   one entity box per request
//   rsp      out  nearest hit, once per request marked last
//   csr      in   ray origin and reciprocal direction
//
// A request is accepted in idle and then takes a scale, a bound and a slab
// step per axis, then a decide step. A last request adds an output step to
// load the response register, and waits there while a prior response stalls.
// Reset is synchronous and restores the register defaults and the search.
// ----------------------------------------------------------------------------
module ray_aabb_closest_hit_picker_unit (
   input logic clock,
   input logic reset,
   rahp_req_if.sink req,
   rahp_rsp_if.source rsp,
   rahp_csr_if.sink csr
);
   import rahp_pkg::*;
   cmd_type cmd;
   logic rsp_busy;

   assign csr.ready = 1'b1;

   rahp_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req.valid),
      .req_last(req.data.last_entity), .rsp_busy(rsp_busy),
      .req_ready(req.ready), .cmd(cmd)
   );

   rahp_datapath u_dp (
      .clock(clock), .reset(reset), .csr_we(csr.valid), .csr_index(csr.index),
      .csr_wdata(csr.wdata), .req_data(req.data), .cmd(cmd),
      .rsp_ready(rsp.ready), .rsp_valid(rsp.valid), .rsp_data(rsp.data),
      .rsp_busy(rsp_busy)
   );
endmodule

// ===== sv/rahp_checker.sv =====
// ----------------------------------------------------------------------------
// rahp_checker
// Port level checks of the ray box hit picker.
// ----------------------------------------------------------------------------
`include "ray_aabb_closest_hit_picker_unit_assert.svh"
module rahp_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_found,
   input logic [15:0] rsp_hit_id,
   input logic [30:0] rsp_hit_distance
);
   `RAHP_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready)
   `RAHP_ASSERT_IMPL(a_noid, clock, reset, rsp_valid && !rsp_found, rsp_hit_id == 16'd0)
   `RAHP_ASSERT_IMPL(a_nodist, clock, reset, rsp_valid && !rsp_found,
      rsp_hit_distance == 31'd0)
   `RAHP_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
endmodule

bind ray_aabb_closest_hit_picker_unit rahp_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_found(rsp.data.found),
   .rsp_hit_id(rsp.data.hit_id), .rsp_hit_distance(rsp.data.hit_distance)
);
